>>> sv/qvs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the quadrature velocity smoother.
package qvs_pkg;

   localparam int VEL_BITS  = 40;             // velocity word, signed, FRAC_BITS fraction
   localparam int GAIN_BITS = 16;             // Q0.16 averaging gain
   localparam int RATE_BITS = 16;             // sample rate in hertz
   localparam int SQ_BITS   = 2 * VEL_BITS;   // squared magnitude
   localparam int HALF_BITS = VEL_BITS / 2;   // squarer operand width
   localparam int GAIN_FRAC = 16;

   localparam logic [GAIN_BITS-1:0] GAIN_MIN   = 16'd13107;   // 0.2
   localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 16'd52429;   // 0.8
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd32768;
   localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd1000;

   // register map
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LANE,
      S_ROOT,
      S_SEND
   } state_type;

   // command from the sequencer to both axis lanes
   typedef struct packed {
      logic                 start;
      logic                 restart;
      logic [RATE_BITS-1:0] rate;
      logic [GAIN_BITS-1:0] alpha;
   } lane_cmd_type;

endpackage

>>> sv/qvs_lane.sv
`timescale 1ns / 1ps
// One axis lane: count difference, rate scaling, exponential average, square.
module qvs_lane import qvs_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lane_cmd_type               cmd,
   input  logic [COUNT_BITS-1:0]      count,
   output logic                       done,
   output logic signed [VEL_BITS-1:0] avg,
   output logic [SQ_BITS-1:0]         square
);

   localparam int PROD_BITS = COUNT_BITS + RATE_BITS;
   localparam int EXT_BITS  = (PROD_BITS + FRAC_BITS > VEL_BITS + 1) ?
                              PROD_BITS + FRAC_BITS : VEL_BITS + 1;
   localparam logic [EXT_BITS-1:0] SAT_LIM = EXT_BITS'(1) << (VEL_BITS - 1);
   localparam logic signed [VEL_BITS-1:0] V_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
   localparam logic signed [VEL_BITS-1:0] V_MIN = {1'b1, {(VEL_BITS-1){1'b0}}};
   localparam int DIF_BITS = VEL_BITS + 1;
   localparam int P_BITS   = DIF_BITS + GAIN_BITS + 1;

   localparam logic [3:0] STEP_MUL  = 4'd1;
   localparam logic [3:0] STEP_SAT  = 4'd2;
   localparam logic [3:0] STEP_DIF  = 4'd3;
   localparam logic [3:0] STEP_GAIN = 4'd4;
   localparam logic [3:0] STEP_AVG  = 4'd5;
   localparam logic [3:0] STEP_ABS  = 4'd6;
   localparam logic [3:0] STEP_SQ0  = 4'd7;
   localparam logic [3:0] STEP_SQ1  = 4'd8;
   localparam logic [3:0] STEP_SQ2  = 4'd9;
   localparam logic [3:0] STEP_SQ3  = 4'd10;

   logic                        busy_ff, done_ff;
   logic [3:0]                  step_ff;
   logic [COUNT_BITS-1:0]       prev_ff;
   logic signed [VEL_BITS-1:0]  avg_ff, avg_in;
   logic                        neg_ff, rst_ff;
   logic [COUNT_BITS-1:0]       mag_ff, mag_in, diff;
   logic [PROD_BITS-1:0]        prod_ff, prod_in;
   logic [EXT_BITS-1:0]         shifted;
   logic signed [VEL_BITS-1:0]  vraw_ff, vraw_in;
   logic signed [DIF_BITS-1:0]  dif_ff, dif_in;
   logic signed [P_BITS-1:0]    p_ff, p_in;
   logic [VEL_BITS-1:0]         abs_ff, abs_in;
   logic [HALF_BITS-1:0]        op_a, op_b;
   logic [VEL_BITS-1:0]         sqp_ff, sqp_in;
   logic [SQ_BITS-1:0]          acc_ff;
   logic                        big;

   // wrapping difference, magnitude and sign
   always_comb begin
      diff   = count - prev_ff;
      mag_in = diff[COUNT_BITS-1] ? (~diff + 1'b1) : diff;
   end

   always_comb begin
      prod_in = PROD_BITS'(mag_ff) * PROD_BITS'(cmd.rate);
      shifted = EXT_BITS'(prod_ff) << FRAC_BITS;
      big     = shifted >= SAT_LIM;
      if (neg_ff) begin
         vraw_in = big ? V_MIN : -$signed(shifted[VEL_BITS-1:0]);
      end else begin
         vraw_in = big ? V_MAX : $signed(shifted[VEL_BITS-1:0]);
      end
      dif_in = DIF_BITS'(vraw_ff) - DIF_BITS'(avg_ff);
      p_in   = dif_ff * $signed({1'b0, cmd.alpha});
      // floor of the gain product: arithmetic shift
      avg_in = rst_ff ? '0 : avg_ff + p_ff[GAIN_FRAC +: VEL_BITS];
      abs_in = avg_ff[VEL_BITS-1] ? (~avg_ff + 1'b1) : avg_ff;
      op_a   = (step_ff == STEP_SQ0) ? abs_ff[HALF_BITS-1:0] : abs_ff[VEL_BITS-1:HALF_BITS];
      op_b   = (step_ff == STEP_SQ2) ? abs_ff[VEL_BITS-1:HALF_BITS] : abs_ff[HALF_BITS-1:0];
      sqp_in = VEL_BITS'(op_a) * VEL_BITS'(op_b);
   end

   // sequencing and axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         prev_ff <= '0;
         avg_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_MUL;
            prev_ff <= count;
         end else if (busy_ff) begin
            if (step_ff == STEP_SQ3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
            if (step_ff == STEP_AVG) begin
               avg_ff <= avg_in;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         neg_ff <= diff[COUNT_BITS-1];
         mag_ff <= mag_in;
         rst_ff <= cmd.restart;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_MUL:  prod_ff <= prod_in;
            STEP_SAT:  vraw_ff <= vraw_in;
            STEP_DIF:  dif_ff  <= dif_in;
            STEP_GAIN: p_ff    <= p_in;
            STEP_ABS:  abs_ff  <= abs_in;
            STEP_SQ0:  sqp_ff  <= sqp_in;
            STEP_SQ1: begin
               acc_ff <= SQ_BITS'(sqp_ff);
               sqp_ff <= sqp_in;
            end
            STEP_SQ2: begin
               acc_ff <= acc_ff + (SQ_BITS'(sqp_ff) << (HALF_BITS + 1));
               sqp_ff <= sqp_in;
            end
            STEP_SQ3:  acc_ff <= acc_ff + (SQ_BITS'(sqp_ff) << VEL_BITS);
            default: ;
         endcase
      end
   end

   assign done   = done_ff;
   assign avg    = avg_ff;
   assign square = acc_ff;

endmodule

>>> sv/qvs_merge.sv
`timescale 1ns / 1ps
// Merge stage: sums the lane squares and takes a bit-serial integer square root.
module qvs_merge import qvs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SQ_BITS-1:0]  square_x,
   input  logic [SQ_BITS-1:0]  square_y,
   output logic                done,
   output logic [VEL_BITS-1:0] root
);

   localparam int REM_BITS = VEL_BITS + 2;
   localparam int SH_BITS  = VEL_BITS + 4;
   localparam int CNT_BITS = $clog2(VEL_BITS);

   logic                busy_ff, done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [SQ_BITS-1:0]  rad_ff;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [VEL_BITS-1:0] root_ff, root_in;
   logic [SH_BITS-1:0]  rem_sh, trial;
   logic                ge;

   // one result bit per cycle, restoring form
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[SQ_BITS-1 -: 2]};
      trial   = {(SH_BITS-2)'(root_ff), 2'b01};
      ge      = rem_sh >= trial;
      rem_in  = ge ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
      root_in = {root_ff[VEL_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(VEL_BITS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= square_x + square_y;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> sv/quadrature_velocity_smoother.sv
`timescale 1ns / 1ps
// Top level of the quadrature velocity smoother.
//
// Usage:
//  - req_ channel: one word per sample tick with both encoder counts and a
//    restart flag. req_ready is high only while no sample is in work.
//  - rsp_ channel: smoothed X and Y velocity (signed, FRAC_BITS fraction)
//    and the truncated magnitude sqrt(vel_x^2 + vel_y^2).
//  - csr_ channel: index 0 smoothing gain (Q0.16, clamped to 0.2..0.8),
//    index 1 sample rate in hertz. csr_ready is always high; write only
//    while the block is idle.
// Flow: two axis lanes run side by side (rate multiply, average,
//  squaring with a 20x20 multiplier over three passes), the merge stage
//  loads the sum of squares and resolves the root one bit per cycle, and
//  the send state passes the result to the output register. A new sample
//  is taken only after the result of the last one has been loaded.
// The result sits in an output register, so the next sample is taken
//  while an earlier result waits for rsp_ready; a new result is held back
//  until the output register is free.
// Reset clears the counter references and averages to zero, loads the
//  register defaults and empties the output register.
module quadrature_velocity_smoother import qvs_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // sample words
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [COUNT_BITS-1:0]      req_count_x,
   input  logic [COUNT_BITS-1:0]      req_count_y,
   input  logic                       req_restart,
   // result words
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VEL_BITS-1:0] rsp_vel_x,
   output logic signed [VEL_BITS-1:0] rsp_vel_y,
   output logic [VEL_BITS-1:0]        rsp_vel_mag,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [GAIN_BITS-1:0]       csr_wdata
);

   state_type state_ff, state_in;

   logic [GAIN_BITS-1:0] gain_ff, alpha;
   logic [RATE_BITS-1:0] rate_ff;

   lane_cmd_type lane_cmd;
   logic         done_x, done_y;
   logic signed [VEL_BITS-1:0] avg_x, avg_y;
   logic [SQ_BITS-1:0] sq_x, sq_y;

   logic                merge_start, merge_done;
   logic [VEL_BITS-1:0] root;

   logic                       accept, load;
   logic                       rsp_valid_ff;
   logic signed [VEL_BITS-1:0] vel_x_ff, vel_y_ff;
   logic [VEL_BITS-1:0]        vel_mag_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         rate_ff <= RATE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN: gain_ff <= csr_wdata;
            CSR_RATE: rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // gain clamp
   always_comb begin
      if (gain_ff < GAIN_MIN) begin
         alpha = GAIN_MIN;
      end else if (gain_ff > GAIN_MAX) begin
         alpha = GAIN_MAX;
      end else begin
         alpha = gain_ff;
      end
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_LANE;
         S_LANE: if (done_x) state_in = S_ROOT;
         S_ROOT: if (merge_done) state_in = S_SEND;
         S_SEND: if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ready   = 1'b0;
      merge_start = 1'b0;
      load        = 1'b0;
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_LANE: merge_start = done_x & done_y;
         S_ROOT: ;
         S_SEND: load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = req_valid & req_ready;

   always_comb begin
      lane_cmd.start   = accept;
      lane_cmd.restart = req_restart;
      lane_cmd.rate    = rate_ff;
      lane_cmd.alpha   = alpha;
   end

   // two axis lanes in lockstep
   qvs_lane #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .cmd    (lane_cmd),
      .count  (req_count_x),
      .done   (done_x),
      .avg    (avg_x),
      .square (sq_x)
   );

   qvs_lane #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .cmd    (lane_cmd),
      .count  (req_count_y),
      .done   (done_y),
      .avg    (avg_y),
      .square (sq_y)
   );

   // magnitude of the merged lanes
   qvs_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .start    (merge_start),
      .square_x (sq_x),
      .square_y (sq_y),
      .done     (merge_done),
      .root     (root)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vel_x_ff   <= avg_x;
         vel_y_ff   <= avg_y;
         vel_mag_ff <= root;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_vel_x   = vel_x_ff;
   assign rsp_vel_y   = vel_y_ff;
   assign rsp_vel_mag = vel_mag_ff;

endmodule

>>> sv/qvs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the quadrature velocity smoother, bound to the top.
module qvs_checker import qvs_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [VEL_BITS-1:0] rsp_vel_x,
   input logic signed [VEL_BITS-1:0] rsp_vel_y,
   input logic [VEL_BITS-1:0]        rsp_vel_mag
);

   logic [VEL_BITS-1:0] abs_x, abs_y;

   assign abs_x = rsp_vel_x[VEL_BITS-1] ? (~rsp_vel_x + 1'b1) : rsp_vel_x;
   assign abs_y = rsp_vel_y[VEL_BITS-1] ? (~rsp_vel_y + 1'b1) : rsp_vel_y;

   // a stalled result stays valid and its magnitude holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vel_mag))
      else $error("stalled result changed");

   // one sample at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while busy");

   // output register empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

   // magnitude bounds each axis
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_vel_mag >= abs_x && rsp_vel_mag >= abs_y)
      else $error("magnitude below axis velocity");

   // zero vector gives zero magnitude
   a_mag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vel_x == '0 && rsp_vel_y == '0 |-> rsp_vel_mag == '0)
      else $error("nonzero magnitude of zero vector");

endmodule

bind quadrature_velocity_smoother qvs_checker u_qvs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_vel_x   (rsp_vel_x),
   .rsp_vel_y   (rsp_vel_y),
   .rsp_vel_mag (rsp_vel_mag)
);

>>> verif/tb_quadrature_velocity_smoother.sv
`timescale 1ns / 1ps
// Self-checking testbench of the quadrature velocity smoother.
module tb_quadrature_velocity_smoother;
   import qvs_pkg::*;

   localparam int COUNT_W     = 16;
   localparam int FRAC_W      = 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DUT_LATENCY = 53;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_SAMPLES  = 200;
   localparam longint VEL_POS_LIM = 64'sh0000_007F_FFFF_FFFF;
   localparam longint VEL_NEG_LIM = -64'sh0000_0080_0000_0000;

   // one sample word as offered on the req_ channel
   typedef struct packed {
      logic [COUNT_W-1:0] cx;
      logic [COUNT_W-1:0] cy;
      logic               rs;
   } sample_word_type;

   // one result word as seen on the rsp_ channel
   typedef struct packed {
      logic signed [VEL_BITS-1:0] vx;
      logic signed [VEL_BITS-1:0] vy;
      logic [VEL_BITS-1:0]        mag;
   } velocity_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [COUNT_W-1:0]         req_count_x = '0;
   logic [COUNT_W-1:0]         req_count_y = '0;
   logic                       req_restart = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [VEL_BITS-1:0] rsp_vel_x;
   logic signed [VEL_BITS-1:0] rsp_vel_y;
   logic [VEL_BITS-1:0]        rsp_vel_mag;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [GAIN_BITS-1:0]       csr_wdata = '0;

   quadrature_velocity_smoother #(
      .COUNT_BITS (COUNT_W),
      .FRAC_BITS  (FRAC_W)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_count_x (req_count_x),
      .req_count_y (req_count_y),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_vel_x   (rsp_vel_x),
      .rsp_vel_y   (rsp_vel_y),
      .rsp_vel_mag (rsp_vel_mag),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the block: register copies, counter references, averages.
   // ---------------------------------------------------------------------
   logic [GAIN_BITS-1:0] shadow_gain = GAIN_RESET;
   logic [RATE_BITS-1:0] shadow_rate = RATE_RESET;
   logic [COUNT_W-1:0]   shadow_prev_x = '0;
   logic [COUNT_W-1:0]   shadow_prev_y = '0;
   longint               shadow_avg_x = 0;
   longint               shadow_avg_y = 0;

   sample_word_type   pending_samples[$];
   velocity_word_type expected_velocities[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int samples_accepted = 0;
   int error_count = 0;
   int cycle_count = 0;
   logic rsp_hold = 1'b0;

   // stimulus-side counter positions, so deltas look like a moving encoder
   logic [COUNT_W-1:0] enc_x = '0;
   logic [COUNT_W-1:0] enc_y = '0;

   sample_word_type   next_word;
   velocity_word_type want_word;

   // Counts per second with FRAC_W fraction bits, saturated to 40 bits.
   // The top bit of the wrapped difference marks it negative, so the
   // half-range difference goes negative.
   function automatic longint count_rate_velocity(input logic [COUNT_W-1:0] cnt,
                                                  input logic [COUNT_W-1:0] last_cnt,
                                                  input logic [RATE_BITS-1:0] rate);
      logic [COUNT_W-1:0] diff;
      longint             mag;
      diff = cnt - last_cnt;
      mag  = longint'(diff);
      if (diff[COUNT_W-1]) mag = (longint'(1) <<< COUNT_W) - mag;
      mag = (mag * longint'(rate)) <<< FRAC_W;
      if (diff[COUNT_W-1]) return (mag >= -VEL_NEG_LIM) ? VEL_NEG_LIM : -mag;
      return (mag > VEL_POS_LIM) ? VEL_POS_LIM : mag;
   endfunction

   // avg += floor((v - avg) * alpha / 2^16); >>> on a signed longint floors
   function automatic longint smoothed_velocity(input longint acc, input longint v,
                                                input longint alpha);
      longint prod;
      prod = (v - acc) * alpha;
      return acc + (prod >>> GAIN_FRAC);
   endfunction

   // floor(sqrt(x^2 + y^2)), resolved one bit at a time from the top
   function automatic logic [VEL_BITS-1:0] velocity_magnitude(input longint x,
                                                               input longint y);
      logic [40:0] ax, ay, root, trial;
      logic [81:0] sum_sq;
      ax     = 41'(x < 0 ? -x : x);
      ay     = 41'(y < 0 ? -y : y);
      sum_sq = 82'(ax) * 82'(ax) + 82'(ay) * 82'(ay);
      root   = '0;
      for (int b = 40; b >= 0; b--) begin
         trial = root | (41'd1 << b);
         if (82'(trial) * 82'(trial) <= sum_sq) root = trial;
      end
      return root[VEL_BITS-1:0];
   endfunction

   // Advance the shadow by one accepted sample word and return its result.
   function automatic velocity_word_type advance_velocity(input logic [COUNT_W-1:0] cx,
                                                          input logic [COUNT_W-1:0] cy,
                                                          input logic rs);
      velocity_word_type    res;
      logic [GAIN_BITS-1:0] alpha;
      longint               vx, vy;
      res = '0;
      if (rs) begin
         // restart: new reference, averages and result all zero
         shadow_prev_x = cx;
         shadow_prev_y = cy;
         shadow_avg_x  = 0;
         shadow_avg_y  = 0;
         return res;
      end
      alpha = shadow_gain;
      if (alpha < GAIN_MIN) alpha = GAIN_MIN;
      else if (alpha > GAIN_MAX) alpha = GAIN_MAX;
      vx = count_rate_velocity(cx, shadow_prev_x, shadow_rate);
      vy = count_rate_velocity(cy, shadow_prev_y, shadow_rate);
      shadow_prev_x = cx;
      shadow_prev_y = cy;
      shadow_avg_x  = smoothed_velocity(shadow_avg_x, vx, longint'(alpha));
      shadow_avg_y  = smoothed_velocity(shadow_avg_y, vy, longint'(alpha));
      res.vx  = VEL_BITS'(shadow_avg_x);
      res.vy  = VEL_BITS'(shadow_avg_y);
      res.mag = velocity_magnitude(shadow_avg_x, shadow_avg_y);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers queued sample words, predicts on every accepted word.
   // Valid is held until accepted; a new word (or a gap) is chosen only
   // when the slot is empty or is being accepted at this edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_velocities.push_back(
               advance_velocity(req_count_x, req_count_y, req_restart));
            samples_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = pending_samples.pop_front();
               req_valid   <= 1'b1;
               req_count_x <= next_word.cx;
               req_count_y <= next_word.cy;
               req_restart <= next_word.rs;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compares each accepted result word with the oldest
   // prediction; random back-pressure unless a long hold-off is running.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_velocities.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result word: x=%h y=%h mag=%h",
                           rsp_vel_x, rsp_vel_y, rsp_vel_mag);
            end else begin
               want_word = expected_velocities.pop_front();
               if (rsp_vel_x !== want_word.vx || rsp_vel_y !== want_word.vy ||
                   rsp_vel_mag !== want_word.mag) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("result mismatch: exp x=%h y=%h mag=%h got x=%h y=%h mag=%h",
                              want_word.vx, want_word.vy, want_word.mag,
                              rsp_vel_x, rsp_vel_y, rsp_vel_mag);
               end
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-offs: the sender keeps offering, so the output
   // register fills and req_ready drops.
   initial begin
      wait (samples_accepted >= 40);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (700) @(posedge clock);
      rsp_hold <= 1'b0;
      wait (samples_accepted >= 700);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (900) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_sample(input logic [COUNT_W-1:0] x, input logic [COUNT_W-1:0] y,
                               input logic rs);
      pending_samples.push_back('{cx: x, cy: y, rs: rs});
   endtask

   // Register write; only called with the block idle.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [GAIN_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_GAIN) shadow_gain = val;
      else shadow_rate = val;
   endtask

   // Sender pause: wait until every queued word is out and every
   // predicted word is back, then load both registers.
   task automatic drain_and_configure(input logic [GAIN_BITS-1:0] gain,
                                      input logic [RATE_BITS-1:0] rate);
      while (pending_samples.size() != 0 || req_valid || expected_velocities.size() != 0)
         @(negedge clock);
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_RATE, rate);
      @(negedge clock);
   endtask

   // Random encoder traffic: mostly small and medium moves, some jumps,
   // some steps of half range or one count less, a few restarts.
   task automatic queue_random_samples(input int n);
      int                 pick, k;
      logic [COUNT_W-1:0] step;
      logic               rs;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         rs   = 1'b0;
         if (pick < 4) begin
            rs    = 1'b1;
            enc_x = COUNT_W'($urandom);
            enc_y = COUNT_W'($urandom);
         end else if (pick < 72) begin
            k     = $urandom_range(COUNT_W - 1);
            step  = COUNT_W'($urandom) & ((COUNT_W'(1) << k) - 1'b1);
            enc_x = $urandom_range(1) ? enc_x + step : enc_x - step;
            k     = $urandom_range(COUNT_W - 1);
            step  = COUNT_W'($urandom) & ((COUNT_W'(1) << k) - 1'b1);
            enc_y = $urandom_range(1) ? enc_y + step : enc_y - step;
         end else if (pick < 86) begin
            enc_x = COUNT_W'($urandom);
            enc_y = COUNT_W'($urandom);
         end else begin
            case ($urandom_range(2))
               0: enc_x = enc_x + 16'h8000;
               1: enc_x = enc_x + 16'h7FFF;
               default: enc_x = enc_x - 16'h7FFF;
            endcase
            case ($urandom_range(2))
               0: enc_y = enc_y + 16'h8000;
               1: enc_y = enc_y;
               default: enc_y = enc_y - 16'h7FFF;
            endcase
         end
         queue_sample(enc_x, enc_y, rs);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [GAIN_BITS-1:0] gain;
      logic [RATE_BITS-1:0] rate;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 33;
      recv_idle_pct = 48;

      // directed, register defaults: restart, +/-1, half-range both ways
      queue_sample(16'h0000, 16'h0000, 1'b1);
      queue_sample(16'h0001, 16'hFFFF, 1'b0);
      queue_sample(16'h8001, 16'h7FFF, 1'b0);
      queue_sample(16'h8001, 16'h7FFF, 1'b0);
      queue_sample(16'hFFFF, 16'h0000, 1'b1);
      queue_sample(16'h7FFE, 16'h8000, 1'b0);

      // gain below the clamp, top sample rate: largest raw velocities
      drain_and_configure(16'h0000, 16'hFFFF);
      queue_sample(16'hFFFE, 16'h0000, 1'b0);
      queue_sample(16'h7FFD, 16'h7FFF, 1'b0);
      queue_sample(16'hFFFD, 16'h7FFF, 1'b0);
      queue_sample(16'hFFFF, 16'hFFFF, 1'b1);
      queue_sample(16'h7FFE, 16'h7FFE, 1'b0);

      // gain above the clamp, zero rate: averages decay toward zero
      drain_and_configure(16'hFFFF, 16'h0000);
      queue_sample(16'h1234, 16'hABCD, 1'b0);
      queue_sample(16'h5555, 16'hAAAA, 1'b0);
      queue_sample(16'h0000, 16'h0000, 1'b0);

      // exact clamp bounds
      drain_and_configure(GAIN_MIN, 16'd1);
      queue_sample(16'h0010, 16'hFFF0, 1'b0);
      queue_sample(16'h0011, 16'hFFEF, 1'b0);
      drain_and_configure(GAIN_MAX, 16'hFFFF);
      queue_sample(16'h8011, 16'h7FEF, 1'b0);
      queue_sample(16'h0010, 16'h0000, 1'b0);

      // random phases, each with its own register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               gain = GAIN_BITS'($urandom_range(GAIN_MAX, GAIN_MIN));
               rate = RATE_RESET;
            end
            1: begin
               gain = GAIN_BITS'($urandom);
               rate = RATE_BITS'($urandom_range(255, 1));
            end
            2: begin gain = GAIN_MIN;  rate = 16'hFFFF; end
            3: begin gain = GAIN_MAX;  rate = 16'd1; end
            4: begin gain = '0;        rate = '0; end
            5: begin gain = '1;        rate = RATE_BITS'($urandom); end
            default: begin
               gain = GAIN_BITS'($urandom);
               rate = RATE_BITS'($urandom);
            end
         endcase
         drain_and_configure(gain, rate);
         // idle pattern: receiver-heavy gaps, then sender-heavy, then none
         if (ph < 2) begin
            send_idle_pct = 33;
            recv_idle_pct = 48;
         end else if (ph < 4) begin
            send_idle_pct = 48;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queue_random_samples(PHASE_SAMPLES);
      end

      while (pending_samples.size() != 0 || req_valid || expected_velocities.size() != 0)
         @(negedge clock);
      // let any stray result word surface
      repeat (DUT_LATENCY + 8) @(posedge clock);

      if (error_count == 0 && expected_velocities.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
